>>> rtl/dcrb_pkg.sv
package dcrb_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int BASE_W     = 12;
    localparam int ENT_W      = 8;
    localparam int XN_W       = SAMPLE_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_BASE   = 4;

    // Defaults for top-level parameters
    localparam int DEF_MAX_DELAY  = 4096;
    localparam int DEF_LANE_COUNT = 4;

    // Result queue depth, must cover every item in flight
    localparam int OUT_FIFO_DEPTH = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH_3 = 3'd6;

    // Register reset values
    localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = 16'd62259;
    localparam logic [GAIN_W-1:0] DRY_GAIN_RST      = 16'd13107;
    localparam logic [GAIN_W-1:0] WET_GAIN_RST      = 16'd52429;
    localparam logic [BASE_W-1:0] BASE_RST [NUM_BASE] = '{
        12'd3490, 12'd2935, 12'd2329, 12'd1745
    };

    // base/40 as (base*DIV40_K)>>DIV40_S, exact for 12-bit base
    localparam int DIV40_K = 26215;
    localparam int DIV40_S = 20;
    localparam int QUOT_W  = 7;
    // |x|/510 as (|x|*DIV510_K)>>DIV510_S, exact for |x| < 2^15
    localparam int DIV510_K = 32897;
    localparam int DIV510_S = 24;

    localparam int NOISE_GAIN = 66;

    typedef struct packed {
        logic                       valid;
        logic [ENT_W-1:0]           entropy;
        logic signed [XN_W-1:0]     xn;       // input sample plus noise
    } t_lane_in;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] delayed;
    } t_lane_out;

    // 2*e - 255 for an entropy byte, as a 9-bit signed value
    function automatic logic signed [ENT_W:0] centered(input logic [ENT_W-1:0] e);
        centered = $signed({~e[ENT_W-1], e[ENT_W-2:0], 1'b1});
    endfunction

endpackage

>>> rtl/dcrb_in_if.sv
interface dcrb_in_if;
    import dcrb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [ENT_W-1:0]           entropy_0;
    logic [ENT_W-1:0]           entropy_1;
    logic [ENT_W-1:0]           entropy_2;
    logic [ENT_W-1:0]           entropy_3;

    modport source (
        output valid, in_sample, entropy_0, entropy_1, entropy_2, entropy_3,
        input  ready
    );
    modport sink (
        input  valid, in_sample, entropy_0, entropy_1, entropy_2, entropy_3,
        output ready
    );
endinterface

>>> rtl/dcrb_out_if.sv
interface dcrb_out_if;
    import dcrb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;

    modport source (
        output valid, out_sample,
        input  ready
    );
    modport sink (
        input  valid, out_sample,
        output ready
    );
endinterface

>>> rtl/dcrb_ram.sv
module dcrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/dcrb_lane.sv
module dcrb_lane #(
    parameter int MAX_DELAY = dcrb_pkg::DEF_MAX_DELAY,
    localparam int AW = $clog2(MAX_DELAY)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dcrb_pkg::t_lane_in                i_in,
    input  logic [dcrb_pkg::BASE_W-1:0]       i_base,
    input  logic [dcrb_pkg::GAIN_W-1:0]       i_fb_gain,
    input  logic                              i_clr,
    input  logic [AW-1:0]                     i_clr_addr,
    output dcrb_pkg::t_lane_out               o_out
);
    import dcrb_pkg::*;

    localparam int LIM_W   = (AW + 2 > 14) ? AW + 2 : 14;
    localparam int Q40_W   = BASE_W + 15;
    localparam int PROD_W  = 16;
    localparam int MAG_W   = PROD_W - 1;
    localparam int D510_W  = MAG_W + 16;
    localparam int FBP_W   = 2 * SAMPLE_W + 1;
    localparam int MIX_W   = XN_W + 1;
    localparam logic signed [LIM_W-1:0]    LIM_MAX = LIM_W'(MAX_DELAY);
    localparam logic signed [MIX_W-1:0]    CLAMP_HI = MIX_W'(32767);
    localparam logic signed [MIX_W-1:0]    CLAMP_LO = -MIX_W'(32767);
    localparam logic signed [SAMPLE_W-1:0] SAMP_HI = SAMPLE_W'(32767);
    localparam logic signed [SAMPLE_W-1:0] SAMP_LO = -SAMPLE_W'(32767);

    // base/40 follows the register every cycle
    logic [Q40_W-1:0]  q40_full;
    logic [QUOT_W-1:0] r_q;

    // Stage A: entropy scaled by base/40
    logic                     r_a_v;
    logic [ENT_W-1:0]         r_a_ent;
    logic signed [XN_W-1:0]   r_a_xn;
    logic signed [PROD_W:0]   prod_a;

    // Stage B: divide by 510, form the wrap length
    logic                     r_b_v;
    logic signed [PROD_W-1:0] r_b_prod;
    logic signed [XN_W-1:0]   r_b_xn;
    logic [MAG_W-1:0]         mag_b;
    logic [D510_W-1:0]        d510_b;
    logic [QUOT_W-1:0]        dq_b;
    logic signed [LIM_W-1:0]  drift_b;
    logic signed [LIM_W-1:0]  lim_raw_b;
    logic signed [LIM_W-1:0]  lim_b;

    // Stage C: memory read, position advance
    logic                     r_c_v;
    logic signed [LIM_W-1:0]  r_c_lim;
    logic signed [XN_W-1:0]   r_c_xn;
    logic [AW-1:0]            r_pos;
    logic [AW-1:0]            n_pos;
    logic signed [LIM_W-1:0]  pos_inc_c;
    logic                     fwd_c;

    // Stage D: feedback, write-back
    logic                     r_d_v;
    logic [AW-1:0]            r_d_addr;
    logic signed [XN_W-1:0]   r_d_xn;
    logic                     r_d_fwd;
    logic signed [SAMPLE_W-1:0] r_fwd_data;
    logic [SAMPLE_W-1:0]      ram_rdata;
    logic signed [SAMPLE_W-1:0] delayed_d;
    logic signed [FBP_W-1:0]  fbp_d;
    logic signed [XN_W-1:0]   fb_d;
    logic signed [MIX_W-1:0]  mix_sum_d;
    logic signed [SAMPLE_W-1:0] mixed_d;

    // Stage E: delayed sample to the merge
    logic                     r_e_v;
    logic signed [SAMPLE_W-1:0] r_e_delayed;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [SAMPLE_W-1:0]      ram_wdata;

    assign q40_full = Q40_W'(i_base) * Q40_W'(DIV40_K);

    assign prod_a = centered(r_a_ent) * $signed({1'b0, r_q});

    assign mag_b     = MAG_W'(r_b_prod[PROD_W-1] ? -r_b_prod : r_b_prod);
    assign d510_b    = D510_W'(mag_b) * D510_W'(DIV510_K);
    assign dq_b      = d510_b[DIV510_S +: QUOT_W];
    assign drift_b   = r_b_prod[PROD_W-1] ? -LIM_W'(dq_b) : LIM_W'(dq_b);
    assign lim_raw_b = LIM_W'(i_base) + drift_b;
    assign lim_b     = (lim_raw_b > LIM_MAX) ? LIM_MAX : lim_raw_b;

    assign pos_inc_c = LIM_W'(r_pos) + LIM_W'(1);
    assign n_pos     = (pos_inc_c >= r_c_lim) ? '0 : pos_inc_c[AW-1:0];
    // Previous item writes this word at the same edge: take its value
    assign fwd_c     = r_d_v && (r_d_addr == r_pos);

    assign delayed_d = r_d_fwd ? r_fwd_data : $signed(ram_rdata);
    assign fbp_d     = delayed_d * $signed({1'b0, i_fb_gain});
    assign fb_d      = fbp_d[FBP_W-1 -: XN_W];
    assign mix_sum_d = r_d_xn + fb_d;
    assign mixed_d   = (mix_sum_d > CLAMP_HI) ? SAMP_HI :
                       (mix_sum_d < CLAMP_LO) ? SAMP_LO : mix_sum_d[SAMPLE_W-1:0];

    assign ram_we    = i_clr || r_d_v;
    assign ram_waddr = i_clr ? i_clr_addr : r_d_addr;
    assign ram_wdata = i_clr ? '0 : mixed_d;

    dcrb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_pos <= '0;
        end else begin
            r_a_v <= i_in.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            if (r_c_v) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q         <= q40_full[DIV40_S +: QUOT_W];
        r_a_ent     <= i_in.entropy;
        r_a_xn      <= i_in.xn;
        r_b_prod    <= prod_a[PROD_W-1:0];
        r_b_xn      <= r_a_xn;
        r_c_lim     <= lim_b;
        r_c_xn      <= r_b_xn;
        r_d_addr    <= r_pos;
        r_d_xn      <= r_c_xn;
        r_d_fwd     <= fwd_c;
        r_fwd_data  <= mixed_d;
        r_e_delayed <= delayed_d;
    end

    assign o_out.valid   = r_e_v;
    assign o_out.delayed = r_e_delayed;
endmodule

>>> rtl/dcrb_mix.sv
module dcrb_mix #(
    parameter int LANE_COUNT = dcrb_pkg::DEF_LANE_COUNT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dcrb_pkg::t_lane_out                i_lanes [LANE_COUNT],
    input  logic signed [dcrb_pkg::SAMPLE_W-1:0] i_x,
    input  logic [dcrb_pkg::GAIN_W-1:0]        i_dry,
    input  logic [dcrb_pkg::GAIN_W-1:0]        i_wet,
    output logic                               o_valid,
    output logic signed [dcrb_pkg::SAMPLE_W-1:0] o_y
);
    import dcrb_pkg::*;

    localparam int SUM_W  = SAMPLE_W + 3;
    localparam int OFS_W  = 19;
    localparam int DIV_S  = 22;
    localparam int K_W    = DIV_S + 1;
    localparam int AVGP_W = OFS_W + K_W;
    localparam int DIV_K  = ((1 << DIV_S) + LANE_COUNT - 1) / LANE_COUNT;
    localparam int OFS    = LANE_COUNT * 65536;
    localparam int PP_W   = 2 * SAMPLE_W + 1;
    localparam int PS_W   = SAMPLE_W + 1;
    localparam int Y_W    = PS_W + 1;
    localparam logic signed [Y_W-1:0]      Y_HI = Y_W'(32767);
    localparam logic signed [Y_W-1:0]      Y_LO = -Y_W'(32768);
    localparam logic signed [SAMPLE_W-1:0] S_HI = SAMPLE_W'(32767);
    localparam logic signed [SAMPLE_W-1:0] S_LO = SAMPLE_W'(32768);

    logic                     valid_e;
    logic signed [SUM_W-1:0]  sum_e;

    logic                     r_f_v;
    logic signed [SUM_W-1:0]  r_f_sum;
    logic signed [SAMPLE_W-1:0] r_f_x;
    logic [OFS_W-1:0]         sofs_f;
    logic [AVGP_W-1:0]        avgp_f;
    logic signed [PP_W-1:0]   pdp_f;

    logic                     r_g_v;
    logic signed [SAMPLE_W-1:0] r_g_avg;
    logic signed [PS_W-1:0]   r_g_pd;
    logic signed [PP_W-1:0]   pwp_g;

    logic                     r_h_v;
    logic signed [PS_W-1:0]   r_h_pd;
    logic signed [PS_W-1:0]   r_h_pw;
    logic signed [Y_W-1:0]    y_h;

    logic                     r_o_v;
    logic signed [SAMPLE_W-1:0] r_o_y;

    always_comb begin
        valid_e = 1'b1;
        sum_e   = '0;
        for (int l = 0; l < LANE_COUNT; l++) begin
            valid_e = valid_e & i_lanes[l].valid;
            sum_e   = sum_e + SUM_W'(i_lanes[l].delayed);
        end
    end

    // Floor division by the lane count: offset to positive, scale by reciprocal
    assign sofs_f = OFS_W'(r_f_sum) + OFS_W'(OFS);
    assign avgp_f = AVGP_W'(sofs_f) * AVGP_W'(DIV_K);
    assign pdp_f  = r_f_x * $signed({1'b0, i_dry});

    assign pwp_g  = r_g_avg * $signed({1'b0, i_wet});

    assign y_h    = r_h_pd + r_h_pw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_f_v <= valid_e;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_o_v <= r_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_sum <= sum_e;
        r_f_x   <= i_x;
        r_g_avg <= $signed(avgp_f[DIV_S +: SAMPLE_W]);
        r_g_pd  <= pdp_f[PP_W-1 -: PS_W];
        r_h_pd  <= r_g_pd;
        r_h_pw  <= pwp_g[PP_W-1 -: PS_W];
        r_o_y   <= (y_h > Y_HI) ? S_HI : (y_h < Y_LO) ? S_LO : y_h[SAMPLE_W-1:0];
    end

    assign o_valid = r_o_v;
    assign o_y     = r_o_y;
endmodule

>>> rtl/drifting_comb_resonator_bank.sv
// Bank of feedback comb resonators, one lane per resonator, each with its own
// delay memory of MAX_DELAY samples. A sample transfer can happen on every clock:
// the block takes one item per cycle for as long as the result side keeps
// taking results. The rate is set by the lane delay memories, which give
// one read and one write per cycle: each item reads a lane's delayed sample at
// the current position and writes the new one back in the following cycle,
// with a bypass when the next item hits the same word. Up to 16 items may be
// in flight or queued; when the output side stalls, input ready drops once
// that many are held. After reset the delay memories are swept to zero, one
// word per cycle in all lanes at once; no sample is taken during the sweep,
// while register writes are taken as ever.
// Write registers only while the block is idle.
module drifting_comb_resonator_bank #(
    parameter int MAX_DELAY  = dcrb_pkg::DEF_MAX_DELAY,
    parameter int LANE_COUNT = dcrb_pkg::DEF_LANE_COUNT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    dcrb_in_if.sink                            i_sample_if,
    dcrb_out_if.source                         o_sample_if,
    input  logic                               i_cfg_we,
    input  logic [dcrb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dcrb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dcrb_pkg::*;

    localparam int AW     = $clog2(MAX_DELAY);
    localparam int PTR_W  = $clog2(OUT_FIFO_DEPTH);
    localparam int OCC_W  = $clog2(OUT_FIFO_DEPTH + 1);
    // Dry-sample delay depth, matched to the lane pipeline from input transfer to lane output
    localparam int X_DLY  = 5;
    localparam int NMUL_W = 16;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    // Configuration registers
    logic [GAIN_W-1:0] r_fb_gain;
    logic [GAIN_W-1:0] r_dry_gain;
    logic [GAIN_W-1:0] r_wet_gain;
    logic [BASE_W-1:0] r_base [NUM_BASE];

    // Memory sweep after reset
    t_state            r_state;
    logic [AW-1:0]     r_clr_addr;
    logic              clr_last;

    // Input side
    logic                       in_xfer;
    logic [ENT_W-1:0]           ent [NUM_BASE];
    logic signed [NMUL_W-1:0]   noise_mul;
    logic signed [XN_W-1:0]     xn;
    logic signed [SAMPLE_W-1:0] r_x_pipe [X_DLY];

    t_lane_in                   lane_in [LANE_COUNT];
    t_lane_out                  lane_out [LANE_COUNT];

    logic                       mix_valid;
    logic signed [SAMPLE_W-1:0] mix_y;

    // Result queue and occupancy (in flight plus queued)
    logic signed [SAMPLE_W-1:0] r_fifo [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0]           r_wr_ptr;
    logic [PTR_W-1:0]           r_rd_ptr;
    logic [OCC_W-1:0]           r_fcnt;
    logic [OCC_W-1:0]           r_occ;
    logic [OCC_W-1:0]           n_occ;
    logic [OCC_W-1:0]           n_fcnt;
    logic                       out_xfer;

    // ---------------------------------------------------------------
    // Configuration writes; unknown indexes drop silently
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_gain  <= FEEDBACK_GAIN_RST;
            r_dry_gain <= DRY_GAIN_RST;
            r_wet_gain <= WET_GAIN_RST;
            for (int b = 0; b < NUM_BASE; b++) begin
                r_base[b] <= BASE_RST[b];
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FEEDBACK_GAIN: begin
                    r_fb_gain <= i_cfg_data;
                end
                REG_DRY_GAIN: begin
                    r_dry_gain <= i_cfg_data;
                end
                REG_WET_GAIN: begin
                    r_wet_gain <= i_cfg_data;
                end
                REG_BASE_LENGTH_0: begin
                    r_base[0] <= i_cfg_data[BASE_W-1:0];
                end
                REG_BASE_LENGTH_1: begin
                    r_base[1] <= i_cfg_data[BASE_W-1:0];
                end
                REG_BASE_LENGTH_2: begin
                    r_base[2] <= i_cfg_data[BASE_W-1:0];
                end
                REG_BASE_LENGTH_3: begin
                    r_base[3] <= i_cfg_data[BASE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Zero sweep of all delay memories; hold off input until done
    // ---------------------------------------------------------------
    assign clr_last = (r_clr_addr == AW'(MAX_DELAY - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (clr_last) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_clr_addr <= '0;
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input transfer: ready only while running and a queue slot is
    // reserved for every item that may still be in flight
    // ---------------------------------------------------------------
    assign i_sample_if.ready = (r_state == ST_RUN) && (r_occ < OCC_W'(OUT_FIFO_DEPTH));
    assign in_xfer           = i_sample_if.valid && i_sample_if.ready;

    assign ent[0] = i_sample_if.entropy_0;
    assign ent[1] = i_sample_if.entropy_1;
    assign ent[2] = i_sample_if.entropy_2;
    assign ent[3] = i_sample_if.entropy_3;

    // Noise from entropy byte 0, added to the input once for all lanes
    assign noise_mul = centered(ent[0]) * $signed(NMUL_W'(NOISE_GAIN));
    assign xn        = i_sample_if.in_sample
                       + $signed(noise_mul[NMUL_W-1 -: ENT_W]);

    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        assign lane_in[g].valid   = in_xfer;
        assign lane_in[g].entropy = ent[g];
        assign lane_in[g].xn      = xn;

        dcrb_lane #(
            .MAX_DELAY (MAX_DELAY)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_in       (lane_in[g]),
            .i_base     (r_base[g]),
            .i_fb_gain  (r_fb_gain),
            .i_clr      (r_state == ST_CLEAR),
            .i_clr_addr (r_clr_addr),
            .o_out      (lane_out[g])
        );
    end

    // Align the dry sample with the lane outputs
    always_ff @(posedge i_clk) begin
        r_x_pipe[0] <= i_sample_if.in_sample;
        for (int k = 1; k < X_DLY; k++) begin
            r_x_pipe[k] <= r_x_pipe[k-1];
        end
    end

    dcrb_mix #(
        .LANE_COUNT (LANE_COUNT)
    ) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lanes (lane_out),
        .i_x     (r_x_pipe[X_DLY-1]),
        .i_dry   (r_dry_gain),
        .i_wet   (r_wet_gain),
        .o_valid (mix_valid),
        .o_y     (mix_y)
    );

    // ---------------------------------------------------------------
    // Result queue: push every mixed sample, pop on output transfer
    // ---------------------------------------------------------------
    assign out_xfer = o_sample_if.valid && o_sample_if.ready;

    always_comb begin
        n_occ  = r_occ;
        n_fcnt = r_fcnt;
        if (in_xfer) begin
            n_occ = n_occ + OCC_W'(1);
        end
        if (out_xfer) begin
            n_occ  = n_occ - OCC_W'(1);
            n_fcnt = n_fcnt - OCC_W'(1);
        end
        if (mix_valid) begin
            n_fcnt = n_fcnt + OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_fcnt   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_occ  <= n_occ;
            r_fcnt <= n_fcnt;
            if (mix_valid) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mix_valid) begin
            r_fifo[r_wr_ptr] <= mix_y;
        end
    end

    assign o_sample_if.valid      = (r_fcnt != '0);
    assign o_sample_if.out_sample = r_fifo[r_rd_ptr];
endmodule

>>> rtl/dcrb_checker.sv
module dcrb_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [dcrb_pkg::SAMPLE_W-1:0] i_out_sample
);
    import dcrb_pkg::*;

    // Memory sweep starts on reset: no input taken right after it
    a_ready_low_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !i_in_ready
    ) else $error("input ready high right after reset");

    // Queue empties on reset
    a_no_result_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !i_out_valid
    ) else $error("result valid right after reset");

    // Ready only drops when the previous cycle offered an item
    a_ready_drop_cause: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) && $past(i_rst_n) |-> $past(i_in_valid)
    ) else $error("input ready dropped with no item offered");

    // Stalled result holds
    a_result_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample)
    ) else $error("stalled result changed or vanished");
endmodule

bind drifting_comb_resonator_bank dcrb_checker u_dcrb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample_if.valid),
    .i_in_ready   (i_sample_if.ready),
    .i_out_valid  (o_sample_if.valid),
    .i_out_ready  (o_sample_if.ready),
    .i_out_sample (o_sample_if.out_sample)
);
